// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the byte FIFO.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define FCBF_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define FCBF_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/fcbf_pkg.sv -----
// Shared types, codes and sizes of the byte FIFO.
package fcbf_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LEN_W = 7;
	localparam int CAP_W = 7;

	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_END   = 3'd1;
	localparam logic [2:0] CMD_PEEK  = 3'd2;
	localparam logic [2:0] CMD_POP   = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_WRITE  = 2'd1;
	localparam logic [1:0] CELL_SHIFT  = 2'd2;
	localparam logic [1:0] CELL_ROTATE = 2'd3;

	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] CAP_ADDR  = 3'd0;
	localparam logic [CAP_W-1:0]      CAP_RESET = 7'd64;

	typedef struct packed {
		logic [2:0]       command;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] length;
	} cmd_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic        last;
		logic        accepted;
		logic [6:0]  stored_count;
		logic [6:0]  room_left;
		logic        input_has_ended;
		logic        end_of_stream;
		logic [31:0] written_total;
		logic [31:0] read_total;
	} rsp_t;

	// Broadcast to every cell of the row in each cycle.
	typedef struct packed {
		logic [1:0]       op;
		logic [7:0]       wdata;
		logic [CNT_W-1:0] held;
	} cell_ctl_t;

endpackage

// ----- rtl/flow_controlled_byte_fifo_unit.sv -----
// Top level of the byte FIFO: request sequencer, counters and response register.
// Write, end, unknown requests, and pop or peek or read of zero bytes: result in the cycle
// after acceptance, one request per cycle while the response side keeps up.
// Read of n bytes: one byte per cycle from the front cell while the response side keeps up.
// Pop of n bytes: one shift of the cell row per byte. Peek: the row rotates once per
// held byte. Reset clears counters, marks and control, and sets the capacity to 64;
// cell contents are undefined until written.
module flow_controlled_byte_fifo_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  fcbf_pkg::cmd_t                 cmd_data,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output fcbf_pkg::rsp_t                 rsp_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fcbf_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import fcbf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_PEEK = 2'd2;
	localparam logic [1:0] ST_POP  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [31:0]      acc_total_q, acc_total_d;
	logic [31:0]      rem_total_q, rem_total_d;
	logic             ended_q, ended_d;
	logic             done_q, done_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] rot_q, rot_d;
	logic [CAP_W-1:0] cap_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             slot_free, cmd_accept;
	logic             emit, emit_bv, emit_last, emit_acc;
	logic [CNT_W-1:0] eff_cap, room;
	logic [LEN_W-1:0] n;
	logic [7:0]       front_byte;
	cell_ctl_t        ctl;
	rsp_t             emit_rsp;

	fcbf_chain u_chain (
		.clk        (clk),
		.ctl        (ctl),
		.front_byte (front_byte)
	);

	assign slot_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall  = (state_q != ST_IDLE) || !slot_free;
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp_data   = rsp_q;

	assign eff_cap = (cap_q > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
	assign room    = (eff_cap > held_d) ? eff_cap - held_d : '0;
	assign n = (cmd_data.length < LEN_W'(held_q)) ? cmd_data.length : LEN_W'(held_q);

	always_comb begin
		state_d     = state_q;
		held_d      = held_q;
		acc_total_d = acc_total_q;
		rem_total_d = rem_total_q;
		ended_d     = ended_q;
		done_d      = done_q;
		cnt_d       = cnt_q;
		rot_d       = rot_q;
		emit        = 1'b0;
		emit_bv     = 1'b0;
		emit_last   = 1'b1;
		emit_acc    = 1'b0;
		ctl.op      = CELL_HOLD;
		ctl.wdata   = cmd_data.data_byte;
		ctl.held    = held_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_accept) begin
					emit = 1'b1;
					unique case (cmd_data.command)
						CMD_WRITE: begin
							if (held_q < eff_cap) begin
								ctl.op      = CELL_WRITE;
								held_d      = held_q + CNT_W'(1);
								acc_total_d = acc_total_q + 32'd1;
								emit_acc    = 1'b1;
							end
						end
						CMD_END: begin
							ended_d = 1'b1;
							done_d  = (acc_total_q == rem_total_q);
						end
						CMD_PEEK: begin
							if (n != '0) begin
								emit    = 1'b0;
								state_d = ST_PEEK;
								cnt_d   = n;
								rot_d   = held_q;
							end
						end
						CMD_POP, CMD_READ: begin
							held_d      = held_q - CNT_W'(n);
							rem_total_d = rem_total_q + 32'(n);
							if (ended_q) begin
								done_d = (acc_total_q == rem_total_d);
							end
							if (n != '0) begin
								cnt_d = n;
								if (cmd_data.command == CMD_READ) begin
									emit    = 1'b0;
									state_d = ST_READ;
								end else begin
									state_d = ST_POP;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				if (slot_free) begin
					ctl.op    = CELL_SHIFT;
					emit      = 1'b1;
					emit_bv   = 1'b1;
					emit_last = (cnt_q == LEN_W'(1));
					cnt_d     = cnt_q - LEN_W'(1);
					if (cnt_q == LEN_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_POP: begin
				ctl.op = CELL_SHIFT;
				cnt_d  = cnt_q - LEN_W'(1);
				if (cnt_q == LEN_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_PEEK: begin
				// Bytes go out while the row turns; the rest of the turn is silent.
				if (cnt_q != '0) begin
					if (slot_free) begin
						ctl.op    = CELL_ROTATE;
						emit      = 1'b1;
						emit_bv   = 1'b1;
						emit_last = (cnt_q == LEN_W'(1));
						cnt_d     = cnt_q - LEN_W'(1);
						rot_d     = rot_q - CNT_W'(1);
					end
				end else begin
					ctl.op = CELL_ROTATE;
					rot_d  = rot_q - CNT_W'(1);
				end
				if (ctl.op == CELL_ROTATE && rot_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		emit_rsp.byte_valid      = emit_bv;
		emit_rsp.out_byte        = emit_bv ? front_byte : 8'd0;
		emit_rsp.last            = emit_last;
		emit_rsp.accepted        = emit_acc;
		emit_rsp.stored_count    = 7'(held_d);
		emit_rsp.room_left       = 7'(room);
		emit_rsp.input_has_ended = ended_d;
		emit_rsp.end_of_stream   = done_d;
		emit_rsp.written_total   = acc_total_d;
		emit_rsp.read_total      = rem_total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			acc_total_q <= '0;
			rem_total_q <= '0;
			ended_q     <= 1'b0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
			rot_q       <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			held_q      <= held_d;
			acc_total_q <= acc_total_d;
			rem_total_q <= rem_total_d;
			ended_q     <= ended_d;
			done_q      <= done_d;
			cnt_q       <= cnt_d;
			rot_q       <= rot_d;
			if (psel && penable && pwrite && paddr == CAP_ADDR) begin
				cap_q <= pwdata[CAP_W-1:0];
			end
			if (slot_free) begin
				rsp_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			rsp_q <= emit_rsp;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == CAP_ADDR) ? 32'(cap_q) : 32'd0;

endmodule

// ----- rtl/fcbf_cell.sv -----
// One byte cell of the storage row.
module fcbf_cell (
	input  logic                  clk,
	input  logic [fcbf_pkg::IDX_W-1:0] idx,
	input  fcbf_pkg::cell_ctl_t   ctl,
	input  logic [7:0]            next_byte,
	input  logic [7:0]            head_byte,
	output logic [7:0]            value
);
	import fcbf_pkg::*;

	logic [7:0]       value_q;
	logic [CNT_W-1:0] pos;

	assign pos = CNT_W'(idx);
	assign value = value_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_WRITE: begin
				if (pos == ctl.held) begin
					value_q <= ctl.wdata;
				end
			end
			CELL_SHIFT: begin
				value_q <= next_byte;
			end
			CELL_ROTATE: begin
				// The tail of the occupied run takes the front byte back.
				if (pos == ctl.held - CNT_W'(1)) begin
					value_q <= head_byte;
				end else begin
					value_q <= next_byte;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

// ----- rtl/fcbf_chain.sv -----
// Row of byte cells; cell zero holds the front of the queue.
module fcbf_chain (
	input  logic                clk,
	input  fcbf_pkg::cell_ctl_t ctl,
	output logic [7:0]          front_byte
);
	import fcbf_pkg::*;

	logic [7:0] cell_byte [DEPTH];

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic [7:0] nb;
		if (j == DEPTH - 1) begin : g_end
			assign nb = 8'd0;
		end else begin : g_mid
			assign nb = cell_byte[j+1];
		end
		fcbf_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(j)),
			.ctl       (ctl),
			.next_byte (nb),
			.head_byte (cell_byte[0]),
			.value     (cell_byte[j])
		);
	end

	assign front_byte = cell_byte[0];

endmodule

// ----- rtl/fcbf_checker.sv -----
// Port-level checker of the byte FIFO and its binding to the top level.
`include "assert_macros.svh"

module fcbf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input fcbf_pkg::rsp_t rsp_data
);
	import fcbf_pkg::*;

	// A held response keeps its contents.
	`FCBF_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "response changed while stalled")

	// No new request is taken while a response waits.
	`FCBF_CHECK_NOW(a_no_take_when_blocked, rsp_valid && rsp_stall, cmd_stall, "request taken while response blocked")

	// A status-only response always closes its request.
	`FCBF_CHECK_NOW(a_status_last, rsp_valid && !rsp_data.byte_valid, rsp_data.last, "status response without last")

	// Without a byte the byte field reads zero.
	`FCBF_CHECK_NOW(a_byte_zero, rsp_valid && !rsp_data.byte_valid, rsp_data.out_byte == 8'd0, "stray byte on status response")

endmodule

bind flow_controlled_byte_fifo_unit fcbf_checker u_fcbf_checker (.*);
